// ----- rtl/svr_pkg.sv -----
// Shared types and constants for the stepper velocity ramp.
// Holds request, motor-mode, axis-mode and register-index codes; no dependencies.
`default_nettype none

package svr_pkg;

  // Fraction bits of the fixed-point target values.
  localparam int unsigned FracBits = 16;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Request codes.
  localparam logic [2:0] ReqTick    = 3'd0;
  localparam logic [2:0] ReqStepped = 3'd1;
  localparam logic [2:0] ReqRun     = 3'd2;
  localparam logic [2:0] ReqStop    = 3'd3;
  localparam logic [2:0] ReqSetAxis = 3'd4;
  localparam logic [2:0] ReqAddTgt  = 3'd5;

  // Motor modes.
  localparam logic [2:0] MotDisabled = 3'd0;
  localparam logic [2:0] MotAccel    = 3'd1;
  localparam logic [2:0] MotDecel    = 3'd2;
  localparam logic [2:0] MotConst    = 3'd3;
  localparam logic [2:0] MotHold     = 3'd4;

  // Axis modes.
  localparam logic [1:0] AxisIdle  = 2'd0;
  localparam logic [1:0] AxisSeek  = 2'd1;
  localparam logic [1:0] AxisFault = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgAccelStep   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDecelStep   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIndexerStep = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgMotorEnable = 2'd3;

  // Half of one microstep, for rounding the remaining target.
  localparam logic signed [48:0] RoundHalf = 49'sd1 <<< (FracBits - 1);

  localparam logic signed [47:0] Max48 = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] Min48 = {1'b1, {47{1'b0}}};

endpackage

`default_nettype wire

// ----- rtl/svr_req_if.sv -----
// Request channel of the stepper velocity ramp: valid/ready plus request fields.
// Stands alone; no package dependency.
`default_nettype none

interface svr_req_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  req_type;
  logic signed [31:0] target_speed;
  logic signed [23:0] step_amount;
  logic        [1:0]  new_axis_state;

  modport source (output valid, req_type, target_speed, step_amount, new_axis_state,
                  input ready);
  modport sink   (input valid, req_type, target_speed, step_amount, new_axis_state,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/svr_res_if.sv -----
// Result channel of the stepper velocity ramp: valid/ready plus result fields.
// Stands alone; no package dependency.
`default_nettype none

interface svr_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] velocity;
  logic        [2:0]  motor_mode;
  logic        [1:0]  axis_mode;
  logic signed [47:0] phase_error;
  logic signed [31:0] target_steps_left;
  logic               vel_updated;
  logic               mode_updated;

  modport source (output valid, velocity, motor_mode, axis_mode, phase_error,
                  target_steps_left, vel_updated, mode_updated,
                  input ready);
  modport sink   (input valid, velocity, motor_mode, axis_mode, phase_error,
                  target_steps_left, vel_updated, mode_updated,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/stepper_velocity_ramp.sv -----
// Top level of the single-axis trapezoidal stepper velocity ramp.
// Depends on svr_pkg, svr_req_if and svr_res_if.
//
//  Channel  Direction  Handshake           Carries
//  req_i    in         valid/ready         one command or tick item
//  res_o    out        valid/ready         one status item per request item
//  cfg      in         cfg_we_i, no wait   ramp steps, indexer step, enable
//
// An item is captured in the input register; once the result register is empty or
// being accepted, the ramp, classification, multiply and saturating add update the
// state and load the result register. One item per cycle is sustained while res_o is ready.
// Reset clears configuration, axis state and valid flags; no clearing pass is needed.
// A stalled result holds the result register; the input register still takes one further item.
`default_nettype none

module stepper_velocity_ramp (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [svr_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire  [svr_pkg::CfgDataW-1:0]       cfg_wdata_i,
  svr_req_if.sink                            req_i,
  svr_res_if.source                          res_o
);

  // Configuration registers.
  logic [31:0] accel_q, decel_q, idx_step_q;
  logic        enable_q;

  // Input register.
  logic               in_valid_q;
  logic        [2:0]  req_q;
  logic signed [31:0] speed_q;
  logic signed [23:0] amount_q;
  logic        [1:0]  nstate_q;

  // Axis state.
  logic signed [31:0] vel_q, vel_d;
  logic signed [31:0] goal_q, goal_d;
  logic        [2:0]  mphase_q, mphase_d;
  logic        [1:0]  axis_q, axis_d;
  logic signed [47:0] tgt_q, tgt_d;
  logic signed [47:0] phacc_q, phacc_d;
  logic               stat_d;

  // Result register.
  logic               out_valid_q;
  logic signed [31:0] r_vel_q;
  logic        [2:0]  r_mmode_q;
  logic        [1:0]  r_axis_q;
  logic signed [47:0] r_phase_q;
  logic signed [31:0] r_left_q;
  logic               r_vchg_q;
  logic               r_schg_q;

  logic               advance;
  logic signed [48:0] r_old, r_new;
  logic signed [31:0] left_d;
  logic signed [33:0] vx, gx, stepx, vs;
  logic               up, clamp_ns, reach_st, call_cls;
  logic        [2:0]  cls;
  logic signed [64:0] prod;
  logic signed [32:0] inc;
  logic signed [48:0] amount_x;

  function automatic logic [2:0] classify(input logic signed [31:0] v,
                                          input logic signed [31:0] g);
    logic [2:0] n;
    if (g == v) begin
      n = (v != 32'sd0) ? svr_pkg::MotConst : svr_pkg::MotHold;
    end else if (v > 32'sd0) begin
      n = (g > v) ? svr_pkg::MotAccel : svr_pkg::MotDecel;
    end else if (v < 32'sd0) begin
      n = (g < v) ? svr_pkg::MotAccel : svr_pkg::MotDecel;
    end else begin
      n = svr_pkg::MotAccel;
    end
    return n;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
    logic signed [47:0] y;
    if (x[48] != x[47]) begin
      y = x[48] ? svr_pkg::Min48 : svr_pkg::Max48;
    end else begin
      y = x[47:0];
    end
    return y;
  endfunction

  // Remaining target rounded half up to whole microsteps.
  function automatic logic signed [48:0] round_tgt(input logic signed [47:0] t);
    logic signed [48:0] s;
    s = $signed({t[47], t}) + svr_pkg::RoundHalf;
    return s >>> svr_pkg::FracBits;
  endfunction

  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q    <= '0;
      decel_q    <= '0;
      idx_step_q <= '0;
      enable_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        svr_pkg::CfgAccelStep:   accel_q    <= cfg_wdata_i;
        svr_pkg::CfgDecelStep:   decel_q    <= cfg_wdata_i;
        svr_pkg::CfgIndexerStep: idx_step_q <= cfg_wdata_i;
        svr_pkg::CfgMotorEnable: enable_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      req_q    <= req_i.req_type;
      speed_q  <= req_i.target_speed;
      amount_q <= req_i.step_amount;
      nstate_q <= req_i.new_axis_state;
    end
  end

  always_comb begin
    vel_d    = vel_q;
    goal_d   = goal_q;
    mphase_d = mphase_q;
    axis_d   = axis_q;
    tgt_d    = tgt_q;
    phacc_d  = phacc_q;
    stat_d   = 1'b0;
    amount_x = $signed({{25{amount_q[23]}}, amount_q});
    r_old    = round_tgt(tgt_q);

    // Ramp datapath, used by the tick request; cls also serves run and stop requests.
    vx       = '0;
    gx       = '0;
    stepx    = '0;
    vs       = '0;
    up       = 1'b0;
    clamp_ns = 1'b0;
    reach_st = 1'b0;
    call_cls = 1'b0;
    cls      = mphase_q;
    prod     = '0;
    inc      = '0;

    case (req_q)
      svr_pkg::ReqTick: begin
        // Overrun check while seeking: a target passed raises a fault.
        if (axis_q == svr_pkg::AxisSeek) begin
          if ((goal_q > 32'sd0 && r_old <= 49'sd0) || (goal_q < 32'sd0 && r_old >= 49'sd0)) begin
            axis_d = svr_pkg::AxisFault;
            stat_d = 1'b1;
            goal_d = '0;
          end
        end else if (axis_q == svr_pkg::AxisFault) begin
          goal_d = '0;
        end
        if (enable_q) begin
          vx    = $signed({{2{vel_q[31]}}, vel_q});
          gx    = $signed({{2{goal_d[31]}}, goal_d});
          stepx = $signed({2'b00, (mphase_q == svr_pkg::MotAccel) ? accel_q : decel_q});
          up    = vel_q < goal_d;
          vs    = up ? (vx + stepx) : (vx - stepx);
          clamp_ns = up ? (vs >= gx) : (vs <= gx);
          reach_st = up ? (vs > gx) : (vs < gx);
          if (mphase_q == svr_pkg::MotAccel || mphase_q == svr_pkg::MotDecel) begin
            if (vel_q != goal_d) begin
              vel_d = clamp_ns ? goal_d : vs[31:0];
            end
            // Accelerating reclassifies on reaching the goal, decelerating
            // only on overshooting it.
            call_cls = (vel_q == goal_d) ||
                       ((mphase_q == svr_pkg::MotAccel) ? clamp_ns : reach_st);
          end else begin
            call_cls = vel_q != goal_d;
          end
          cls = classify(vel_d, goal_d);
          if (call_cls) begin
            mphase_d = cls;
            if (cls != mphase_q) begin
              stat_d = 1'b1;
            end
          end
          prod    = $signed(vel_d) * $signed({1'b0, idx_step_q});
          inc     = prod[64:32];
          phacc_d = sat48($signed({phacc_q[47], phacc_q}) + $signed({{16{inc[32]}}, inc}));
        end
      end
      svr_pkg::ReqStepped: begin
        phacc_d = sat48($signed({phacc_q[47], phacc_q}) - amount_x);
        if (axis_q == svr_pkg::AxisSeek) begin
          tgt_d = sat48($signed({tgt_q[47], tgt_q}) - amount_x);
        end
      end
      svr_pkg::ReqRun, svr_pkg::ReqStop: begin
        goal_d   = (req_q == svr_pkg::ReqRun) ? speed_q : 32'sd0;
        cls      = classify(vel_q, goal_d);
        mphase_d = cls;
        stat_d   = cls != mphase_q;
      end
      svr_pkg::ReqSetAxis: begin
        if (nstate_q == svr_pkg::AxisIdle || nstate_q == svr_pkg::AxisSeek ||
            nstate_q == svr_pkg::AxisFault) begin
          axis_d = nstate_q;
          stat_d = nstate_q != axis_q;
        end
      end
      svr_pkg::ReqAddTgt: begin
        tgt_d = sat48($signed({tgt_q[47], tgt_q}) + amount_x);
      end
      default: ;
    endcase

    r_new = round_tgt(tgt_d);
    if (r_new[48:31] == {18{r_new[48]}}) begin
      left_d = r_new[31:0];
    end else begin
      left_d = r_new[48] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q    <= '0;
      goal_q   <= '0;
      mphase_q <= svr_pkg::MotHold;
      axis_q   <= svr_pkg::AxisIdle;
      tgt_q    <= '0;
      phacc_q  <= '0;
    end else if (advance) begin
      vel_q    <= vel_d;
      goal_q   <= goal_d;
      mphase_q <= mphase_d;
      axis_q   <= axis_d;
      tgt_q    <= tgt_d;
      phacc_q  <= phacc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      r_vel_q   <= vel_d;
      r_mmode_q <= enable_q ? mphase_d : svr_pkg::MotDisabled;
      r_axis_q  <= axis_d;
      r_phase_q <= phacc_d;
      r_left_q  <= left_d;
      r_vchg_q  <= vel_d != vel_q;
      r_schg_q  <= stat_d;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.velocity          = r_vel_q;
  assign res_o.motor_mode        = r_mmode_q;
  assign res_o.axis_mode         = r_axis_q;
  assign res_o.phase_error       = r_phase_q;
  assign res_o.target_steps_left = r_left_q;
  assign res_o.vel_updated       = r_vchg_q;
  assign res_o.mode_updated      = r_schg_q;

endmodule

`default_nettype wire
